[sv/dstoi_pkg.sv]
// Shared types and constants for the decimal string to integer converter.
package dstoi_pkg;

  localparam int unsigned ResultBits = 32;
  localparam int unsigned MagBits    = ResultBits - 1;
  localparam int unsigned ProdBits   = MagBits + 4;

  localparam logic [7:0] CharMinus = 8'h2D;
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharNine  = 8'h39;

  localparam logic [ResultBits-1:0] ValueMax = {1'b0, {MagBits{1'b1}}};
  localparam logic [ResultBits-1:0] ValueMin = {1'b1, {MagBits{1'b0}}};

  typedef enum logic [2:0] {
    PhStart  = 3'b001,
    PhDigits = 3'b010,
    PhDone   = 3'b100
  } phase_e;

  typedef struct packed {
    phase_e             phase;
    logic               negative;
    logic [MagBits-1:0] magnitude;
    logic               overflowed;
  } parse_state_t;

  localparam parse_state_t StateReset = '{
    phase:      PhStart,
    negative:   1'b0,
    magnitude:  '0,
    overflowed: 1'b0
  };

endpackage

[sv/dstoi_step.sv]
// Per-character parser update and result formation.
module dstoi_step (
  input  dstoi_pkg::parse_state_t           st_i,
  input  logic [7:0]                        ch_i,
  input  logic                              last_i,
  output dstoi_pkg::parse_state_t           st_o,
  output logic [dstoi_pkg::ResultBits-1:0]  value_o,
  output logic                              saturated_o
);

  dstoi_pkg::parse_state_t            nxt;
  logic [3:0]                         digit;
  logic                               is_digit;
  logic [dstoi_pkg::ProdBits-1:0]     mag_ext;
  logic [dstoi_pkg::ProdBits-1:0]     prod;

  assign digit    = 4'(ch_i - dstoi_pkg::CharZero);
  assign is_digit = (ch_i >= dstoi_pkg::CharZero) && (ch_i <= dstoi_pkg::CharNine);
  assign mag_ext  = {4'b0000, st_i.magnitude};
  assign prod     = (mag_ext << 3) + (mag_ext << 1)
                  + {{(dstoi_pkg::ProdBits-4){1'b0}}, digit};

  always_comb begin
    nxt = st_i;
    priority if (st_i.phase == dstoi_pkg::PhDone) begin
      nxt = st_i;
    end else if (st_i.phase == dstoi_pkg::PhStart && ch_i == dstoi_pkg::CharMinus) begin
      nxt.negative = 1'b1;
      nxt.phase    = dstoi_pkg::PhDigits;
    end else if (is_digit) begin
      if (prod[dstoi_pkg::ProdBits-1:dstoi_pkg::MagBits] != '0) begin
        nxt.overflowed = 1'b1;
        nxt.phase      = dstoi_pkg::PhDone;
      end else begin
        nxt.magnitude = prod[dstoi_pkg::MagBits-1:0];
        nxt.phase     = dstoi_pkg::PhDigits;
      end
    end else begin
      nxt.phase = dstoi_pkg::PhDone;
    end
  end

  always_comb begin
    if (nxt.overflowed) begin
      value_o = nxt.negative ? dstoi_pkg::ValueMin : dstoi_pkg::ValueMax;
    end else if (nxt.negative) begin
      value_o = {dstoi_pkg::ResultBits{1'b0}} - {1'b0, nxt.magnitude};
    end else begin
      value_o = {1'b0, nxt.magnitude};
    end
  end

  assign saturated_o = nxt.overflowed;
  assign st_o        = last_i ? dstoi_pkg::StateReset : nxt;

endmodule

[sv/decimal_string_to_int_saturating.sv]
// Top level of the streaming decimal string to saturating integer converter.
//
// Characters arrive one byte per item on the input channel (ch_i, last_i),
// and last_i marks the final character of a string. One result item
// (value_o, saturated_o) is produced for each string, on its final character.
// Both channels use valid and stall; an item moves when valid is high and
// stall is low.
// An accepted character is registered in the input register, then the parser
// update runs combinationally and a final character's result is registered
// in the output register. One character is taken every cycle unless the input stalls.
// The output is a register, and the input register lets characters that
// produce no result continue while a result waits. A final character stalls
// the input only while the previous result is still held by a stalled
// receiver.
// Reset empties both registers and returns the parser to the start of a
// string.
module decimal_string_to_int_saturating (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [7:0]                           ch_i,
  input  logic                                 last_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [dstoi_pkg::ResultBits-1:0] value_o,
  output logic                                 saturated_o
);

  logic                                in_valid_q;
  logic [7:0]                          ch_q;
  logic                                last_q;
  logic                                out_valid_q;
  logic [dstoi_pkg::ResultBits-1:0]    value_q;
  logic                                saturated_q;
  dstoi_pkg::parse_state_t             st_q;
  dstoi_pkg::parse_state_t             st_d;
  logic [dstoi_pkg::ResultBits-1:0]    value_d;
  logic                                saturated_d;
  logic                                out_free;
  logic                                consume;
  logic                                accept;

  dstoi_step u_step (
    .st_i        (st_q),
    .ch_i        (ch_q),
    .last_i      (last_q),
    .st_o        (st_d),
    .value_o     (value_d),
    .saturated_o (saturated_d)
  );

  assign out_free   = !out_valid_q || !out_stall_i;
  assign consume    = in_valid_q && (!last_q || out_free);
  assign in_stall_o = in_valid_q && !consume;
  assign accept     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      st_q        <= dstoi_pkg::StateReset;
    end else begin
      if (accept) begin
        in_valid_q <= 1'b1;
      end else if (consume) begin
        in_valid_q <= 1'b0;
      end
      if (consume && last_q) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (consume) begin
        st_q <= st_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      ch_q   <= ch_i;
      last_q <= last_i;
    end
    if (consume && last_q) begin
      value_q     <= value_d;
      saturated_q <= saturated_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign value_o     = $signed(value_q);
  assign saturated_o = saturated_q;

  a_sat_extreme : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && saturated_o |->
      (value_q == dstoi_pkg::ValueMax || value_q == dstoi_pkg::ValueMin))
    else $error("Saturated result is not a range limit.");

  a_start_clean : assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.phase == dstoi_pkg::PhStart |->
      (st_q.magnitude == '0 && !st_q.overflowed && !st_q.negative))
    else $error("Parser at start of string holds stale state.");

  a_ovf_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.overflowed |-> st_q.phase == dstoi_pkg::PhDone)
    else $error("Overflow did not end parsing.");

  a_result_load : assert property (@(posedge clk_i) disable iff (!rst_ni)
    consume && last_q |=> out_valid_q)
    else $error("Final character produced no result.");

  a_stall_cause : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (in_valid_q && last_q && out_valid_q && out_stall_i))
    else $error("Input stalled without a blocked result.");

endmodule
